[design/bsba_pkg.sv]
// Shared types and constants for the boolean score bucket accumulator.
`timescale 1ns / 1ps
`default_nettype none
package bsba_pkg;

    localparam int BUCKETS_DEF       = 1024;
    localparam int COORD_ENTRIES_DEF = 64;

    localparam int DOC_W   = 31;
    localparam int SCORE_W = 32;
    localparam int MASK_W  = 32;
    localparam int CIDX_W  = 6;
    localparam int CVAL_W  = 17;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = SCORE_W + CVAL_W;

    localparam int DOC_LSB   = 0;
    localparam int SCORE_LSB = DOC_LSB + DOC_W;
    localparam int MASK_LSB  = SCORE_LSB + SCORE_W;
    localparam int CIDX_LSB  = MASK_LSB + MASK_W;
    localparam int CVAL_LSB  = CIDX_LSB + CIDX_W;
    localparam int IN_BITS   = CVAL_LSB + CVAL_W;
    localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = DOC_W + SCORE_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int KIND_W   = 2;
    localparam int M_TUSER_W = 2;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [CNT_W-1:0]  CNT_MAX    = 6'd63;
    localparam logic [CVAL_W-1:0] COORD_ONE  = 17'h10000;
    localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(32'h8000);

    typedef enum logic [KIND_W-1:0] {
        KIND_COLLECT = 2'd0,
        KIND_DRAIN   = 2'd1,
        KIND_LOAD    = 2'd2
    } kind_t;

    typedef enum logic {
        REG_REQUIRED   = 1'b0,
        REG_PROHIBITED = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic item_load;
        logic coll_brd;
        logic coll_srd;
        logic coll_wr;
        logic drn_chk;
        logic drn_brd;
        logic drn_crd;
        logic drn_mul;
        logic out_load;
        logic coord_ld;
        logic mem_clr;
    } bsba_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic clr_done;
        logic out_free;
    } bsba_stat_t;

endpackage
`default_nettype wire

[design/bsba_ctrl.sv]
// Controller state machine that sequences collect, drain, load and memory clear.
`timescale 1ns / 1ps
`default_nettype none
module bsba_ctrl (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [bsba_pkg::KIND_W-1:0]    s_tuser,
    input  wire bsba_pkg::bsba_stat_t           stat,
    output bsba_pkg::bsba_cmd_t                 cmd
);
    import bsba_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_C_BRD,
        S_C_SRD,
        S_C_WR,
        S_D_CHK,
        S_D_BRD,
        S_D_CRD,
        S_D_MUL,
        S_D_OUT,
        S_L_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: begin
                if (stat.clr_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    case (kind_t'(s_tuser))
                        KIND_COLLECT: state_next = S_C_BRD;
                        KIND_DRAIN:   state_next = S_D_CHK;
                        KIND_LOAD:    state_next = S_L_WR;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_C_BRD: state_next = S_C_SRD;
            S_C_SRD: state_next = S_C_WR;
            S_C_WR:  state_next = S_IDLE;
            S_D_CHK: state_next = stat.count_zero ? S_D_OUT : S_D_BRD;
            S_D_BRD: state_next = S_D_CRD;
            S_D_CRD: state_next = S_D_MUL;
            S_D_MUL: state_next = S_D_OUT;
            S_D_OUT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_L_WR:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == S_IDLE);
        cmd           = '0;
        cmd.item_load = (state_reg == S_IDLE) && s_tvalid;
        cmd.coll_brd  = (state_reg == S_C_BRD);
        cmd.coll_srd  = (state_reg == S_C_SRD);
        cmd.coll_wr   = (state_reg == S_C_WR);
        cmd.drn_chk   = (state_reg == S_D_CHK);
        cmd.drn_brd   = (state_reg == S_D_BRD);
        cmd.drn_crd   = (state_reg == S_D_CRD);
        cmd.drn_mul   = (state_reg == S_D_MUL);
        cmd.out_load  = (state_reg == S_D_OUT) && stat.out_free;
        cmd.coord_ld  = (state_reg == S_L_WR);
        cmd.mem_clr   = (state_reg == S_CLEAR);
    end

endmodule
`default_nettype wire

[design/bsba_dp.sv]
// Datapath: bucket, touched-stack and coordination memories, scaling and result register.
`timescale 1ns / 1ps
`default_nettype none
module bsba_dp #(
    parameter int BUCKETS       = bsba_pkg::BUCKETS_DEF,
    parameter int COORD_ENTRIES = bsba_pkg::COORD_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [bsba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic [bsba_pkg::MASK_W-1:0]      required_mask,
    input  wire logic [bsba_pkg::MASK_W-1:0]      prohibited_mask,
    input  wire bsba_pkg::bsba_cmd_t              cmd,
    output bsba_pkg::bsba_stat_t                  stat,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bsba_pkg::M_TDATA_W-1:0]        m_tdata,   // hit_doc, hit_score, zero pad
    output logic [bsba_pkg::M_TUSER_W-1:0]        m_tuser,   // matched, empty_res
    output logic                                  m_tlast
);
    import bsba_pkg::*;

    localparam int IW    = $clog2(BUCKETS);
    localparam int CNTW  = IW + 1;
    localparam int CW    = $clog2(COORD_ENTRIES);
    localparam int CLR_N = (BUCKETS > COORD_ENTRIES) ? BUCKETS : COORD_ENTRIES;
    localparam int CLRW  = $clog2(CLR_N);

    typedef struct packed {
        logic [IW-1:0]      pos;
        logic [CNT_W-1:0]   cnt;
        logic [MASK_W-1:0]  bits;
        logic [SCORE_W-1:0] sum;
        logic [DOC_W-1:0]   doc;
    } bucket_t;

    bucket_t            bk_mem [BUCKETS];
    logic [IW-1:0]      stk_mem [BUCKETS];
    logic [CVAL_W-1:0]  coord_mem [COORD_ENTRIES];

    logic [DOC_W-1:0]   doc_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [CIDX_W-1:0]  cidx_reg;
    logic [CVAL_W-1:0]  cval_reg;

    bucket_t            bk_rd_reg;
    logic [IW-1:0]      stk_rd_reg;
    logic [CVAL_W-1:0]  coord_rd_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CNTW-1:0]    count_reg;
    logic [CNTW-1:0]    count_next;
    logic [CLRW-1:0]    clr_addr_reg;
    logic               empty_reg;
    logic               last_reg;

    logic               valid_reg;
    logic [DOC_W-1:0]   out_doc_reg;
    logic [SCORE_W-1:0] out_score_reg;
    logic               out_matched_reg;
    logic               out_empty_reg;
    logic               out_last_reg;

    logic [IW-1:0]      idx;
    logic               bk_live;
    logic               bk_same;
    logic               push;
    logic [SCORE_W:0]   sum_wide;
    bucket_t            bk_wdata;
    logic               bk_we;
    logic [IW-1:0]      bk_waddr;
    bucket_t            bk_din;
    logic               bk_re;
    logic [IW-1:0]      bk_raddr;
    logic               stk_re;
    logic [IW-1:0]      stk_raddr;
    logic               coord_we;
    logic [CW-1:0]      coord_waddr;
    logic [CVAL_W-1:0]  coord_wdata;
    logic [CW-1:0]      coord_raddr;
    logic [PROD_W:0]    rounded;
    logic [SCORE_W-1:0] scaled;
    logic               matched;

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            doc_reg   <= s_tdata[DOC_LSB +: DOC_W];
            score_reg <= s_tdata[SCORE_LSB +: SCORE_W];
            mask_reg  <= s_tdata[MASK_LSB +: MASK_W];
            cidx_reg  <= s_tdata[CIDX_LSB +: CIDX_W];
            cval_reg  <= s_tdata[CVAL_LSB +: CVAL_W];
        end
    end

    assign idx      = doc_reg[IW-1:0];
    assign bk_live  = ({1'b0, bk_rd_reg.pos} < count_reg) && (stk_rd_reg == idx);
    assign bk_same  = bk_live && (bk_rd_reg.doc == doc_reg);
    assign push     = !bk_live && (count_reg != CNTW'(BUCKETS));
    assign sum_wide = {1'b0, bk_rd_reg.sum} + {1'b0, score_reg};

    always_comb begin
        if (bk_same) begin
            bk_wdata      = bk_rd_reg;
            bk_wdata.sum  = sum_wide[SCORE_W] ? '1 : sum_wide[SCORE_W-1:0];
            bk_wdata.bits = bk_rd_reg.bits | mask_reg;
            bk_wdata.cnt  = (bk_rd_reg.cnt < CNT_MAX) ? bk_rd_reg.cnt + 1'b1 : CNT_MAX;
        end else begin
            bk_wdata.doc  = doc_reg;
            bk_wdata.sum  = score_reg;
            bk_wdata.bits = mask_reg;
            bk_wdata.cnt  = CNT_W'(1);
            bk_wdata.pos  = push ? count_reg[IW-1:0] : bk_rd_reg.pos;
        end
    end

    assign bk_we    = cmd.coll_wr ||
                      (cmd.mem_clr && (32'(clr_addr_reg) < 32'(BUCKETS)));
    assign bk_waddr = cmd.mem_clr ? IW'(clr_addr_reg) : idx;
    assign bk_din   = cmd.mem_clr ? '0 : bk_wdata;
    assign bk_re    = cmd.coll_brd || cmd.drn_brd;
    assign bk_raddr = cmd.coll_brd ? idx : stk_rd_reg;

    always_ff @(posedge aclk) begin
        if (bk_we) begin
            bk_mem[bk_waddr] <= bk_din;
        end
        if (bk_re) begin
            bk_rd_reg <= bk_mem[bk_raddr];
        end
    end

    assign stk_re    = cmd.coll_srd || (cmd.drn_chk && !stat.count_zero);
    assign stk_raddr = cmd.coll_srd ? bk_rd_reg.pos : count_next[IW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.coll_wr && push) begin
            stk_mem[count_reg[IW-1:0]] <= idx;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    assign count_next      = count_reg - 1'b1;
    assign stat.count_zero = (count_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.coll_wr && push) begin
            count_reg <= count_reg + 1'b1;
        end else if (cmd.drn_chk && !stat.count_zero) begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.drn_chk) begin
            empty_reg <= stat.count_zero;
            last_reg  <= (count_reg == CNTW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.mem_clr) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    assign stat.clr_done = (clr_addr_reg == CLRW'(CLR_N - 1));

    assign coord_we    = (cmd.mem_clr && (32'(clr_addr_reg) < 32'(COORD_ENTRIES))) ||
                         (cmd.coord_ld && (32'(cidx_reg) < 32'(COORD_ENTRIES)));
    assign coord_waddr = cmd.mem_clr ? CW'(clr_addr_reg) : CW'(cidx_reg);
    assign coord_wdata = cmd.mem_clr ? '0 :
                         ((cval_reg > COORD_ONE) ? COORD_ONE : cval_reg);
    assign coord_raddr = (32'(bk_rd_reg.cnt) >= 32'(COORD_ENTRIES)) ?
                         CW'(COORD_ENTRIES - 1) : CW'(bk_rd_reg.cnt);

    always_ff @(posedge aclk) begin
        if (coord_we) begin
            coord_mem[coord_waddr] <= coord_wdata;
        end
        if (cmd.drn_crd) begin
            coord_rd_reg <= coord_mem[coord_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.drn_mul) begin
            prod_reg <= bk_rd_reg.sum * coord_rd_reg;
        end
    end

    assign rounded = {1'b0, prod_reg} + ROUND_HALF;
    assign scaled  = (rounded[PROD_W:16+SCORE_W] != '0) ? '1 : rounded[16 +: SCORE_W];
    assign matched = ((bk_rd_reg.bits & prohibited_mask) == '0) &&
                     ((bk_rd_reg.bits & required_mask) == required_mask);

    assign stat.out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_doc_reg     <= empty_reg ? '0 : bk_rd_reg.doc;
            out_score_reg   <= empty_reg ? '0 : scaled;
            out_matched_reg <= !empty_reg && matched;
            out_empty_reg   <= empty_reg;
            out_last_reg    <= !empty_reg && last_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = M_TDATA_W'({out_score_reg, out_doc_reg});
    assign m_tuser  = {out_empty_reg, out_matched_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

[design/boolean_score_bucket_accumulator.sv]
// Top level: configuration registers, controller and datapath of the score bucket accumulator.
//
// Input items arrive on s_tvalid/s_tready/s_tdata with the item kind on s_tuser:
// collect a clause hit, drain one touched bucket, or load a coordination factor.
// Each drain item yields one result on m_tvalid/m_tready/m_tdata; m_tuser carries the
// matched and empty flags and m_tlast marks the last touched bucket. Collect and load
// items give no result. Masks are to be written over the APB port (0x0 required, 0x4
// prohibited) only while the block is idle; the block itself does not enforce this.
// pready is always high. One item is handled at a time: a collect does a bucket read,
// stack read and bucket write, a load one coordination write, and a drain a count
// check, bucket read, coordination read and the registered multiply before loading the
// result (an empty drain goes from the check to the result load). The result register
// lets the next item enter while a result waits; a drain that finds the result register
// still full holds until m_tready. After reset the bucket memory and the coordination
// table are cleared one entry per cycle over the larger of BUCKETS and COORD_ENTRIES
// addresses (1024 by default) with s_tready low; the touched count and masks reset to zero.
`timescale 1ns / 1ps
`default_nettype none
module boolean_score_bucket_accumulator #(
    parameter int BUCKETS       = bsba_pkg::BUCKETS_DEF,
    parameter int COORD_ENTRIES = bsba_pkg::COORD_ENTRIES_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [bsba_pkg::S_TDATA_W-1:0]   s_tdata,  // doc, score, clause_mask, coord_index, coord_value
    input  wire logic [bsba_pkg::KIND_W-1:0]      s_tuser,  // kind
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [bsba_pkg::M_TDATA_W-1:0]        m_tdata,  // hit_doc, hit_score
    output logic [bsba_pkg::M_TUSER_W-1:0]        m_tuser,  // matched, empty_res
    output logic                                  m_tlast,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bsba_pkg::APB_AW-1:0]      paddr,
    input  wire logic [bsba_pkg::APB_DW-1:0]      pwdata,
    output logic [bsba_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);
    import bsba_pkg::*;

    logic [MASK_W-1:0] required_reg;
    logic [MASK_W-1:0] prohibited_reg;
    logic              cfg_wr;
    bsba_cmd_t         cmd;
    bsba_stat_t        stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            required_reg   <= '0;
            prohibited_reg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[2]))
                REG_REQUIRED:   required_reg   <= pwdata;
                REG_PROHIBITED: prohibited_reg <= pwdata;
                default:        required_reg   <= required_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_REQUIRED:   prdata = required_reg;
            REG_PROHIBITED: prdata = prohibited_reg;
            default:        prdata = '0;
        endcase
    end

    bsba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    bsba_dp #(
        .BUCKETS       (BUCKETS),
        .COORD_ENTRIES (COORD_ENTRIES)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .required_mask   (required_reg),
        .prohibited_mask (prohibited_reg),
        .cmd             (cmd),
        .stat            (stat),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast)
    );

endmodule
`default_nettype wire

[tb/sv/bsba_checker.sv]
// Checker for the score bucket accumulator: bucket predictor, expected hit queue and result compare.
`timescale 1ns / 1ps
module bsba_checker #(
    parameter int BUCKETS       = bsba_pkg::BUCKETS_DEF,
    parameter int COORD_ENTRIES = bsba_pkg::COORD_ENTRIES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bsba_pkg::S_TDATA_W-1:0] s_tdata,   // doc, score, clause_mask, coord_index, coord_value
    input  logic [bsba_pkg::KIND_W-1:0]    s_tuser,   // kind
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bsba_pkg::M_TDATA_W-1:0] m_tdata,   // hit_doc, hit_score
    input  logic [bsba_pkg::M_TUSER_W-1:0] m_tuser,   // matched, empty_res
    input  logic                           m_tlast,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bsba_pkg::APB_AW-1:0]    paddr,
    input  logic [bsba_pkg::APB_DW-1:0]    pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             outstanding
);
    import bsba_pkg::*;

    localparam int IDX_W = $clog2(BUCKETS);

    typedef struct packed {
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
        logic               matched;
        logic               empty;
        logic               last;
    } hit_t;

    logic [MASK_W-1:0]  required_bits;
    logic [MASK_W-1:0]  prohibited_bits;
    logic               live         [BUCKETS];
    logic [DOC_W-1:0]   bucket_doc   [BUCKETS];
    logic [SCORE_W-1:0] bucket_sum   [BUCKETS];
    logic [MASK_W-1:0]  bucket_bits  [BUCKETS];
    logic [CNT_W-1:0]   bucket_count [BUCKETS];
    logic [IDX_W-1:0]   touched      [BUCKETS];
    logic [CVAL_W-1:0]  coord        [COORD_ENTRIES];
    int                 depth;
    hit_t               hit_queue [$];

    initial begin
        required_bits   = '0;
        prohibited_bits = '0;
        foreach (live[i]) live[i] = 1'b0;
        foreach (coord[i]) coord[i] = '0;
        depth       = 0;
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void absorb_hit(input logic [DOC_W-1:0] doc,
                                       input logic [SCORE_W-1:0] score,
                                       input logic [MASK_W-1:0] mask);
        logic [IDX_W-1:0] idx;
        logic [SCORE_W:0] total;
        idx = doc[IDX_W-1:0];
        if (live[idx] && bucket_doc[idx] == doc) begin
            total = {1'b0, bucket_sum[idx]} + {1'b0, score};
            bucket_sum[idx] = total[SCORE_W] ? '1 : total[SCORE_W-1:0];
            bucket_bits[idx] |= mask;
            if (bucket_count[idx] != CNT_MAX) bucket_count[idx]++;
        end else begin
            if (!live[idx] && depth < BUCKETS) begin
                live[idx]      = 1'b1;
                touched[depth] = idx;
                depth++;
            end
            bucket_doc[idx]   = doc;
            bucket_sum[idx]   = score;
            bucket_bits[idx]  = mask;
            bucket_count[idx] = CNT_W'(1);
        end
    endfunction

    function automatic hit_t pop_bucket();
        hit_t             h;
        logic [IDX_W-1:0] idx;
        int               c;
        logic [63:0]      prod;
        h = '0;
        if (depth == 0) begin
            h.empty = 1'b1;
            return h;
        end
        depth--;
        idx = touched[depth];
        live[idx] = 1'b0;
        c = int'(bucket_count[idx]);
        if (c >= COORD_ENTRIES) c = COORD_ENTRIES - 1;
        prod = (64'(bucket_sum[idx]) * 64'(coord[c]) + 64'h8000) >> 16;
        h.doc     = bucket_doc[idx];
        h.score   = (prod > 64'hFFFF_FFFF) ? '1 : prod[SCORE_W-1:0];
        h.matched = ((bucket_bits[idx] & prohibited_bits) == '0) &&
                    ((bucket_bits[idx] & required_bits) == required_bits);
        h.last    = (depth == 0);
        return h;
    endfunction

    function automatic void store_factor(input logic [CIDX_W-1:0] cidx,
                                         input logic [CVAL_W-1:0] cval);
        if (int'(cidx) < COORD_ENTRIES) coord[cidx] = (cval > COORD_ONE) ? COORD_ONE : cval;
    endfunction

    task automatic check_field(input string name, input logic [SCORE_W-1:0] want,
                               input logic [SCORE_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        hit_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_AW-1:2]))
                    REG_REQUIRED:   required_bits   = pwdata[MASK_W-1:0];
                    REG_PROHIBITED: prohibited_bits = pwdata[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (hit_queue.size() == 0) begin
                    $error("unexpected result: hit_doc 0x%0h with no drain waiting",
                           m_tdata[DOC_W-1:0]);
                    mismatches++;
                end else begin
                    want = hit_queue.pop_front();
                    check_field("hit_doc", SCORE_W'(want.doc), SCORE_W'(m_tdata[DOC_W-1:0]));
                    check_field("hit_score", want.score, m_tdata[DOC_W +: SCORE_W]);
                    check_field("matched", SCORE_W'(want.matched), SCORE_W'(m_tuser[0]));
                    check_field("empty_res", SCORE_W'(want.empty), SCORE_W'(m_tuser[1]));
                    check_field("last", SCORE_W'(want.last), SCORE_W'(m_tlast));
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    KIND_COLLECT: absorb_hit(s_tdata[DOC_LSB +: DOC_W],
                                             s_tdata[SCORE_LSB +: SCORE_W],
                                             s_tdata[MASK_LSB +: MASK_W]);
                    KIND_DRAIN:   hit_queue.insert(hit_queue.size(), pop_bucket());
                    KIND_LOAD:    store_factor(s_tdata[CIDX_LSB +: CIDX_W],
                                               s_tdata[CVAL_LSB +: CVAL_W]);
                    default: ;
                endcase
            end
            outstanding = hit_queue.size();
        end
    end

endmodule

[tb/sv/tb.sv]
// Testbench top: clock, reset, item and register stimulus, and verdict for the score bucket accumulator.
`timescale 1ns / 1ps
module tb;
    import bsba_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDX_W       = $clog2(BUCKETS_DEF);
    localparam int SETTLE      = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 75;
    localparam int PHASES      = 6;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // doc, score, clause_mask, coord_index, coord_value
    logic [KIND_W-1:0]    s_tuser  = '0;   // kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // hit_doc, hit_score
    logic [M_TUSER_W-1:0] m_tuser;         // matched, empty_res
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    int                   mismatches;
    int                   outstanding;
    int                   items_sent = 0;
    int                   burst_left = 1;
    bit                   hold_req   = 1'b0;

    boolean_score_bucket_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    bsba_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .pready(pready), .mismatches(mismatches), .outstanding(outstanding)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1000000;
        $display("status: fail");
        $finish;
    end

    // Receiver: segments of always-ready, random and mostly-stalled, plus one long hold-off.
    initial begin
        int mode;
        int span;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 150);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic offer(input logic [KIND_W-1:0] kind, input logic [DOC_W-1:0] doc,
                         input logic [SCORE_W-1:0] score, input logic [MASK_W-1:0] mask,
                         input logic [CIDX_W-1:0] cidx, input logic [CVAL_W-1:0] cval);
        logic took;
        int   gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'({cval, cidx, mask, score, doc});
        do begin
            @(negedge aclk);
            took = s_tready;
            @(posedge aclk);
        end while (!took);
        if (kind != KIND_UNUSED) items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic collect_hit(input logic [DOC_W-1:0] doc, input logic [SCORE_W-1:0] score,
                               input logic [MASK_W-1:0] mask);
        offer(KIND_COLLECT, doc, score, mask, CIDX_W'($urandom()), CVAL_W'($urandom()));
    endtask

    task automatic drain_one();
        offer(KIND_DRAIN, DOC_W'($urandom()), $urandom(), $urandom(),
              CIDX_W'($urandom()), CVAL_W'($urandom()));
    endtask

    task automatic load_coord(input logic [CIDX_W-1:0] cidx, input logic [CVAL_W-1:0] cval);
        offer(KIND_LOAD, DOC_W'($urandom()), $urandom(), $urandom(), cidx, cval);
    endtask

    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return $urandom();
            2:       return '0;
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom();
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return 32'h1 << $urandom_range(0, 7);
        endcase
    endfunction

    task automatic noise();
        case ($urandom_range(0, 3))
            0:       load_coord(CIDX_W'($urandom()), CVAL_W'($urandom()));
            1:       offer(KIND_UNUSED, DOC_W'($urandom()), $urandom(), $urandom(),
                           CIDX_W'($urandom()), CVAL_W'($urandom()));
            2:       drain_one();
            default: collect_hit(DOC_W'($urandom()), pick_score(), pick_mask());
        endcase
    endtask

    // Collect hits over a small document set, some sharing a bucket, then drain it, sometimes in part.
    task automatic run_query(input int docs_n, input int hits_n);
        logic [DOC_W-1:0] pool [$];
        logic [DOC_W-1:0] d;
        int               drains;
        for (int i = 0; i < docs_n; i++) begin
            d = DOC_W'($urandom());
            if (i > 0 && $urandom_range(0, 3) == 0)
                d[IDX_W-1:0] = pool[$urandom_range(0, i - 1)][IDX_W-1:0];
            pool.insert(pool.size(), d);
        end
        for (int h = 0; h < hits_n; h++) begin
            if ($urandom_range(0, 11) == 0) noise();
            collect_hit(pool[$urandom_range(0, docs_n - 1)], pick_score(), pick_mask());
        end
        drains = ($urandom_range(0, 7) == 0) ? $urandom_range(0, docs_n) : docs_n + 1;
        repeat (drains) drain_one();
    endtask

    task automatic run_random(input int budget);
        int start;
        start = items_sent;
        while (items_sent - start < budget) begin
            if ($urandom_range(0, 9) == 0) noise();
            else run_query($urandom_range(1, 12), $urandom_range(1, 30));
        end
    endtask

    task automatic apb_write(input reg_idx_t r, input logic [APB_DW-1:0] value);
        logic ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(negedge aclk);
            ready = pready;
            @(posedge aclk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Drop valid and wait until every drain result is in and the block is idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (outstanding == 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [MASK_W-1:0] req;
        logic [MASK_W-1:0] pro;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin req = '0; pro = '0; end
                1: begin req = '1; pro = '0; end
                2: begin req = '0; pro = '1; end
                3: begin req = 32'h0000_0003; pro = 32'h0000_0080; end
                4: begin req = $urandom_range(1, 15); pro = 32'h1 << $urandom_range(4, 7); end
                default: begin req = '1; pro = '1; end
            endcase
            apb_write(REG_REQUIRED, req);
            apb_write(REG_PROHIBITED, pro);
            if (p == 0) begin
                drain_one();
                load_coord(6'd1, 17'h1FFFF);
                load_coord(6'd2, 17'h08000);
                load_coord(6'd63, 17'h0C000);
                load_coord(6'd0, 17'h00000);
                offer(KIND_UNUSED, '1, '1, '1, '1, '1);
                collect_hit(31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
                collect_hit(31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001);
                drain_one();
                collect_hit(31'h7FFF_FFFF, 32'h0000_0007, 32'h0000_0002);
                collect_hit(31'h0000_03FF, 32'h0000_0005, 32'h0000_0000);
                collect_hit(31'h0000_0000, 32'h0001_8000, 32'h0000_0002);
                collect_hit(31'h0000_0000, 32'h0000_0001, 32'h0000_0004);
                drain_one();
                collect_hit(31'h0000_0000, 32'h0000_0003, 32'h0000_0000);
                drain_one();
                drain_one();
                drain_one();
                for (int i = 0; i < 64; i++)
                    load_coord(CIDX_W'(i), ($urandom_range(0, 3) == 0) ?
                               CVAL_W'($urandom()) : CVAL_W'($urandom_range(0, 32'h10000)));
            end
            if (p == 1) run_query(1, 70);
            if (p == 2) hold_req = 1'b1;
            run_random(PHASE_ITEMS);
            settle();
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
